@@ src/fsne_pkg.sv @@
package fsne_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ECHO,
        S_SIGN,
        S_MUL,
        S_DIG,
        S_DEC_OUT,
        S_PRE0,
        S_PREX,
        S_HEX_SKIP,
        S_HEX_OUT
    } t_state;

    // Character codes
    localparam logic [7:0] CH_PCT   = 8'd37;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_UP_A  = 8'd65;
    localparam logic [7:0] CH_UP_X  = 8'd88;
    localparam logic [7:0] CH_LO_A  = 8'd97;
    localparam logic [7:0] CH_LO_D  = 8'd100;
    localparam logic [7:0] CH_LO_I  = 8'd105;
    localparam logic [7:0] CH_LO_X  = 8'd120;

    // Divide by ten through a reciprocal multiply: q = (x * RECIP_TEN) >> RECIP_SHIFT
    localparam int          DATA_W      = 32;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Number of 4-bit digits held for a decimal conversion
    localparam int DEC_DIGITS = 10;

    // Map a nibble to its ASCII hex digit
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UP_A : CH_LO_A;
        if (nib < 4'd10) begin
            hex_ascii = CH_ZERO + {4'b0, nib};
        end else begin
            hex_ascii = base + {4'b0, nib - 4'd10};
        end
    endfunction

endpackage

@@ src/format_string_number_expander.sv @@
// Printf-style integer formatter. Each input transaction carries one format character and a
// 32-bit argument; output transactions carry one ASCII character each, with o_last marking the
// final character caused by that input. An ordinary character is echoed, '%' arms a pending
// specifier, and d/i, x, X after it print the argument as signed decimal or "0x" plus hex.
// The block takes one input transaction at a time and raises o_in_stall until its final
// character is loaded into the output register. Hex prints "0x", skips leading zero nibbles
// (keeping at least one) and prints the rest. Decimal prints '-' for a negative argument,
// runs each digit through the divide-by-ten unit (S_MUL, then S_DIG), then prints the
// digits, most significant first. Output back-pressure stalls the states that emit.
module format_string_number_expander
    import fsne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_fmt_char,
    input  logic [31:0] i_arg_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    localparam int DIG_W = 4 * DEC_DIGITS;

    t_state             r_state, n_state;
    logic               r_pending, n_pending;
    logic               r_upper, n_upper;
    logic [DATA_W-1:0]  r_mag, n_mag;
    logic [DATA_W-1:0]  r_hex, n_hex;
    logic [DIG_W-1:0]   r_digits, n_digits;
    logic [3:0]         r_nd, n_nd;
    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_out_last;

    logic               w_accept;
    logic               w_out_free;
    logic               w_emit;
    logic [7:0]         w_emit_char;
    logic               w_emit_last;
    logic               w_div_start;
    logic [DATA_W-1:0]  w_quot;
    logic [3:0]         w_rem;

    // Divide-by-ten unit, reused for every decimal digit
    fsne_div10 u_div10 (
        .i_clk      (i_clk),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
        end
    end

    // Hold working registers
    always_ff @(posedge i_clk) begin
        r_upper  <= n_upper;
        r_mag    <= n_mag;
        r_hex    <= n_hex;
        r_digits <= n_digits;
        r_nd     <= n_nd;
    end

    // Sequence one input transaction
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_upper     = r_upper;
        n_mag       = r_mag;
        n_hex       = r_hex;
        n_digits    = r_digits;
        n_nd        = r_nd;
        w_emit      = 1'b0;
        w_emit_char = r_mag[7:0];
        w_emit_last = 1'b0;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!r_pending) begin
                        if (i_fmt_char == CH_PCT) begin
                            n_pending = 1'b1;
                        end else begin
                            n_mag   = {24'b0, i_fmt_char};
                            n_state = S_ECHO;
                        end
                    end else begin
                        n_pending = 1'b0;
                        n_nd      = 4'd0;
                        priority if (i_fmt_char == CH_LO_D || i_fmt_char == CH_LO_I) begin
                            if (i_arg_value[DATA_W-1]) begin
                                n_mag   = ~i_arg_value + 32'd1;
                                n_state = S_SIGN;
                            end else begin
                                n_mag   = i_arg_value;
                                n_state = S_MUL;
                            end
                        end else if (i_fmt_char == CH_LO_X || i_fmt_char == CH_UP_X) begin
                            n_hex   = i_arg_value;
                            n_upper = (i_fmt_char == CH_UP_X);
                            n_nd    = 4'd8;
                            n_state = S_PRE0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_ECHO: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = r_mag[7:0];
                    w_emit_last = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_MINUS;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                w_div_start = 1'b1;
                n_state     = S_DIG;
            end
            S_DIG: begin
                // push the digit; the newest (most significant) sits at the bottom
                n_digits = {r_digits[DIG_W-5:0], w_rem};
                n_nd     = r_nd + 4'd1;
                n_mag    = w_quot;
                n_state  = (w_quot == '0) ? S_DEC_OUT : S_MUL;
            end
            S_DEC_OUT: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_ZERO + {4'b0, r_digits[3:0]};
                    w_emit_last = (r_nd == 4'd1);
                    n_digits    = {4'b0, r_digits[DIG_W-1:4]};
                    n_nd        = r_nd - 4'd1;
                    if (r_nd == 4'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PRE0: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_ZERO;
                    n_state     = S_PREX;
                end
            end
            S_PREX: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_LO_X;
                    n_state     = S_HEX_SKIP;
                end
            end
            S_HEX_SKIP: begin
                // drop leading zero nibbles, keep at least one
                if (r_hex[DATA_W-1:DATA_W-4] == 4'd0 && r_nd > 4'd1) begin
                    n_hex = {r_hex[DATA_W-5:0], 4'b0};
                    n_nd  = r_nd - 4'd1;
                end else begin
                    n_state = S_HEX_OUT;
                end
            end
            S_HEX_OUT: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_char = hex_ascii(r_hex[DATA_W-1:DATA_W-4], r_upper);
                    w_emit_last = (r_nd == 4'd1);
                    n_hex       = {r_hex[DATA_W-5:0], 4'b0};
                    n_nd        = r_nd - 4'd1;
                    if (r_nd == 4'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Load the output register or drop a taken transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= w_emit_char;
            r_out_last <= w_emit_last;
        end
    end

    // Checks
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (w_rem < 4'd10))
        else $error("decimal remainder out of range");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (r_nd < 4'(DEC_DIGITS)))
        else $error("decimal digit count overflow");

    a_pct_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_pending && i_fmt_char == CH_PCT) |=> (r_pending && r_state == S_IDLE))
        else $error("percent did not arm the specifier");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_last) |=> (r_state == S_IDLE && !r_pending))
        else $error("final character did not end the transaction");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

endmodule

@@ src/fsne_div10.sv @@
module fsne_div10
    import fsne_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_start,
    input  logic [DATA_W-1:0]   i_dividend,
    output logic [DATA_W-1:0]   o_quot,
    output logic [3:0]          o_rem
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

    logic [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0] w_q10;

    // Register the reciprocal product; dividend is held by the caller meanwhile
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_dividend) * PROD_W'(RECIP_TEN);
        end
    end

    // Take the quotient, then recover the remainder from the low nibble
    assign o_quot = {{(DATA_W - QUOT_W){1'b0}}, r_prod[PROD_W-1:RECIP_SHIFT]};
    assign w_q10  = {o_quot[DATA_W-4:0], 3'b0} + {o_quot[DATA_W-2:0], 1'b0};
    assign o_rem  = i_dividend[3:0] - w_q10[3:0];

endmodule
